/* hdl/tccs_pkg.sv */
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, command codes and control/status structs for the text
// console cursor and scroll unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLS * ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;
  localparam int PCNT_W = $clog2(TAB_STOP + 1);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0700;
  localparam logic [7:0]        COLOR_RESET = 8'd7;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_PUT    = 3'd3;
  localparam logic [2:0] OP_LINE   = 3'd4;
  localparam logic [2:0] OP_SCROLL = 3'd5;
  localparam logic [2:0] OP_CR     = 3'd6;
  localparam logic [2:0] OP_READ   = 3'd7;

  localparam logic REG_TEXT_COLOR  = 1'b0;
  localparam logic REG_BLANK_COLOR = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic       fin;
  } tccs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic last_row;
    logic wrap;
    logic put_last;
    logic put_zero;
    logic blank_last;
    logic col_zero;
    logic cr_last;
  } tccs_stat_t;

endpackage

`default_nettype wire

/* hdl/tccs_ram.sv */
// ----------------------------------------------------------------------------
// tccs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/tccs_ctrl.sv */
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: clearing pass, request dispatch, put, line, scroll, carriage
// return and read steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 req_type,
  input  logic [7:0]           char_code,
  input  tccs_pkg::tccs_stat_t stat,
  output tccs_pkg::tccs_cmd_t  cmd,
  output logic                 busy
);

  import tccs_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PUT    = 3'd2;
  localparam logic [2:0] S_LINE   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_CR     = 3'd5;
  localparam logic [2:0] S_RD1    = 3'd6;
  localparam logic [2:0] S_RD2    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.fin    = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (req_type) begin
            state_next = S_RD1;
          end else if (char_code == CH_NEWLINE) begin
            state_next = S_LINE;
          end else if (char_code == CH_RETURN) begin
            state_next = S_CR;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_PUT: begin
        cmd.op = OP_PUT;
        if (stat.wrap && stat.last_row) begin
          state_next = S_SCROLL;
        end else if (stat.put_last) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LINE: begin
        cmd.op = OP_LINE;
        if (stat.last_row) begin
          state_next = S_SCROLL;
        end else begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCROLL: begin
        cmd.op = OP_SCROLL;
        if (stat.blank_last) begin
          if (stat.put_zero) begin
            cmd.fin    = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_CR: begin
        if (stat.col_zero) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_CR;
          if (stat.cr_last) begin
            cmd.fin    = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_RD1: begin
        cmd.op     = OP_READ;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/tccs_dpath.sv */
// ----------------------------------------------------------------------------
// tccs_dpath
// Cursor, scroll offset, step counters, cell address generation, cell RAM
// and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  tccs_pkg::tccs_cmd_t          cmd,
  output tccs_pkg::tccs_stat_t         stat,
  input  logic                         req_type,
  input  logic [7:0]                   char_code,
  input  logic                         end_of_text,
  input  logic [tccs_pkg::ROW_W-1:0]   read_row,
  input  logic [tccs_pkg::COL_W-1:0]   read_col,
  input  logic [7:0]                   text_color,
  input  logic [7:0]                   blank_color,
  output logic [7:0]                   cell_char,
  output logic [7:0]                   cell_color,
  output logic [tccs_pkg::ROW_W-1:0]   cursor_row,
  output logic [tccs_pkg::COL_W-1:0]   cursor_col,
  output logic                         write_done,
  output logic                         done
);

  import tccs_pkg::*;

  localparam logic [ROW_W:0] ROWS_EXT = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0] COLS_EXT = (COL_W + 1)'(COLS);

  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  top;
  logic [ROW_W-1:0]  top_next;
  logic [ROW_W-1:0]  top_adv;
  logic [ADDR_W-1:0] clr_cnt;
  logic [COL_W-1:0]  blank_cnt;
  logic [PCNT_W-1:0] put_cnt;
  logic [PCNT_W-1:0] tab_n;
  logic              is_read;
  logic              is_tab;
  logic              eot;
  logic [7:0]        ch;
  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic              rd_ok;
  logic              in_range;

  logic [ROW_W-1:0]  lrow;
  logic [COL_W-1:0]  lcol;
  logic [ROW_W:0]    prow_sum;
  logic [ROW_W:0]    prow;
  logic [ADDR_W-1:0] lin_addr;
  logic [ADDR_W-1:0] addr;
  logic              we;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rdata;
  logic [7:0]        put_char;

  assign stat.clr_last   = (clr_cnt == ADDR_W'(CELLS - 1));
  assign stat.last_row   = (row == ROW_W'(ROWS - 1));
  assign stat.wrap       = (col == COL_W'(COLS - 1));
  assign stat.put_last   = (put_cnt == PCNT_W'(1));
  assign stat.put_zero   = (put_cnt == '0);
  assign stat.blank_last = (blank_cnt == COL_W'(COLS - 1));
  assign stat.col_zero   = (col == '0);
  assign stat.cr_last    = (blank_cnt == (col - COL_W'(1)));

  assign tab_n    = PCNT_W'(TAB_STOP - (col % TAB_STOP));
  assign in_range = ({1'b0, read_row} < ROWS_EXT) && ({1'b0, read_col} < COLS_EXT);
  assign top_adv  = (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);
  assign put_char = is_tab ? CH_SPACE : ch;

  always_comb begin
    row_next = row;
    col_next = col;
    top_next = top;
    case (cmd.op)
      OP_PUT: begin
        if (stat.wrap) begin
          col_next = '0;
          if (stat.last_row) begin
            top_next = top_adv;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      OP_LINE: begin
        col_next = '0;
        if (stat.last_row) begin
          top_next = top_adv;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      OP_CR: begin
        if (stat.cr_last) begin
          col_next = '0;
        end
      end
      default: begin
        row_next = row;
      end
    endcase
  end

  always_comb begin
    lrow = row;
    lcol = col;
    case (cmd.op)
      OP_SCROLL: begin
        lrow = ROW_W'(ROWS - 1);
        lcol = blank_cnt;
      end
      OP_CR: begin
        lcol = blank_cnt;
      end
      OP_READ: begin
        lrow = rd_ok ? rd_row : '0;
        lcol = rd_ok ? rd_col : '0;
      end
      default: begin
        lrow = row;
      end
    endcase
  end

  assign prow_sum = {1'b0, lrow} + {1'b0, top};
  assign prow     = (prow_sum >= ROWS_EXT) ? (prow_sum - ROWS_EXT) : prow_sum;
  assign lin_addr = ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(lcol);
  assign addr     = (cmd.op == OP_CLEAR) ? clr_cnt : lin_addr;

  always_comb begin
    we    = 1'b0;
    wdata = {blank_color, CH_SPACE};
    case (cmd.op)
      OP_CLEAR: begin
        we    = 1'b1;
        wdata = CELL_RESET;
      end
      OP_PUT: begin
        we    = 1'b1;
        wdata = {text_color, put_char};
      end
      OP_SCROLL: begin
        we = 1'b1;
      end
      OP_CR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      top     <= '0;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      row  <= row_next;
      col  <= col_next;
      top  <= top_next;
      done <= cmd.fin;
      if (cmd.op == OP_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_read   <= req_type;
        eot       <= end_of_text;
        ch        <= char_code;
        is_tab    <= (char_code == CH_TAB);
        rd_row    <= read_row;
        rd_col    <= read_col;
        rd_ok     <= in_range;
        blank_cnt <= '0;
        if (char_code == CH_TAB) begin
          put_cnt <= tab_n;
        end else if (char_code == CH_NEWLINE) begin
          put_cnt <= '0;
        end else begin
          put_cnt <= PCNT_W'(1);
        end
      end
      OP_PUT: begin
        put_cnt <= put_cnt - PCNT_W'(1);
        if (stat.wrap && stat.last_row) begin
          blank_cnt <= '0;
        end
      end
      OP_LINE: begin
        blank_cnt <= '0;
      end
      OP_SCROLL: begin
        blank_cnt <= blank_cnt + COL_W'(1);
      end
      OP_CR: begin
        blank_cnt <= blank_cnt + COL_W'(1);
      end
      default: begin
        blank_cnt <= blank_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      cursor_row <= row_next;
      cursor_col <= col_next;
      write_done <= is_read ? 1'b0 : eot;
      if (is_read && rd_ok) begin
        cell_char  <= rdata[7:0];
        cell_color <= rdata[15:8];
      end else begin
        cell_char  <= '0;
        cell_color <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/text_console_cursor_scroll_unit.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text console engine: 80x25 cell buffer in a circular row RAM with a
// cursor, tab, carriage return, newline and scroll handling, and cell reads.
//
// Channel   Direction  Handshake             Signals
// request   in         start & !busy         req_type char_code end_of_text
//                                            read_row read_col
// result    out        done (one cycle)      cell_char cell_color cursor_row
//                                            cursor_col write_done
// config    in/out     APB psel&penable      paddr pwdata prdata pready
//
// Steps: a put step per plain character or tab space, a line step per newline,
// a blank write per cell left of the cursor for a carriage return, and a read
// step then a result step for a read. A scroll writes one blank cell per cycle
// on the single RAM write port. After reset, busy is high while the buffer is
// cleared. A result shows on done for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type,
  input  logic [7:0]                 char_code,
  input  logic                       end_of_text,
  input  logic [tccs_pkg::ROW_W-1:0] read_row,
  input  logic [tccs_pkg::COL_W-1:0] read_col,
  output logic                       done,
  output logic [7:0]                 cell_char,
  output logic [7:0]                 cell_color,
  output logic [tccs_pkg::ROW_W-1:0] cursor_row,
  output logic [tccs_pkg::COL_W-1:0] cursor_col,
  output logic                       write_done,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import tccs_pkg::*;

  logic       text_color;
  logic [7:0] text_color_q;
  logic [7:0] blank_color_q;
  logic       cfg_wr;
  tccs_cmd_t  cmd;
  tccs_stat_t stat;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign text_color = (paddr[2] == REG_TEXT_COLOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color_q  <= COLOR_RESET;
      blank_color_q <= COLOR_RESET;
    end else if (cfg_wr) begin
      if (text_color) begin
        text_color_q <= pwdata[7:0];
      end else begin
        blank_color_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'd0, (paddr[2] == REG_BLANK_COLOR) ? blank_color_q : text_color_q};

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .char_code (char_code),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  tccs_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .read_row    (read_row),
    .read_col    (read_col),
    .text_color  (text_color_q),
    .blank_color (blank_color_q),
    .cell_char   (cell_char),
    .cell_color  (cell_color),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .write_done  (write_done),
    .done        (done)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a busy cycle before it");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cursor_row <= ROW_W'(ROWS - 1) && cursor_col <= COL_W'(COLS - 1)))
    else $error("cursor out of range");
`endif

endmodule

`default_nettype wire

/* verif/tccs_console_checker.sv */
// ----------------------------------------------------------------------------
// tccs_console_checker
// Watches the request, result and APB channels of the text console unit. It
// keeps its own copy of the cell buffer, cursor and color registers, predicts
// the report for every accepted request, and compares each done strobe with
// the oldest prediction. APB reads are checked against the color registers.
// ----------------------------------------------------------------------------
module tccs_console_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       req_type,
  input  logic [7:0]                 char_code,
  input  logic                       end_of_text,
  input  logic [tccs_pkg::ROW_W-1:0] read_row,
  input  logic [tccs_pkg::COL_W-1:0] read_col,
  input  logic                       done,
  input  logic [7:0]                 cell_char,
  input  logic [7:0]                 cell_color,
  input  logic [tccs_pkg::ROW_W-1:0] cursor_row,
  input  logic [tccs_pkg::COL_W-1:0] cursor_col,
  input  logic                       write_done,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         errors,
  output int                         outstanding,
  output int                         checked,
  output int                         scrolls
);

  import tccs_pkg::*;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             write_done;
  } console_report_t;

  logic [CELL_W-1:0] screen [0:CELLS-1];
  int                cur_row;
  int                cur_col;
  logic [7:0]        fg_attr;
  logic [7:0]        blank_attr;
  int                err_cnt;
  int                check_cnt;
  int                scroll_cnt;
  console_report_t   predicted_reports [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    checked     = 0;
    scrolls     = 0;
    err_cnt     = 0;
    check_cnt   = 0;
    scroll_cnt  = 0;
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void clear_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen[i] = CELL_RESET;
    cur_row    = 0;
    cur_col    = 0;
    fg_attr    = COLOR_RESET;
    blank_attr = COLOR_RESET;
  endfunction

  function automatic void scroll_screen();
    int i;
    for (i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
    for (i = (ROWS - 1) * COLS; i < CELLS; i++) screen[i] = {blank_attr, CH_SPACE};
    cur_row = ROWS - 1;
    scroll_cnt++;
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) scroll_screen();
  endfunction

  function automatic void store_glyph(logic [7:0] ch);
    screen[cur_row * COLS + cur_col] = {fg_attr, ch};
    cur_col++;
    if (cur_col >= COLS) advance_line();
  endfunction

  function automatic console_report_t predict_report(logic read_req, logic [7:0] ch,
                                                     logic eot, logic [ROW_W-1:0] rr,
                                                     logic [COL_W-1:0] rc);
    console_report_t r;
    int              pad;
    int              c;
    r = '0;
    if (read_req) begin
      if (rr < ROWS && rc < COLS) {r.cell_color, r.cell_char} = screen[rr * COLS + rc];
    end else begin
      r.write_done = eot;
      case (ch)
        CH_NEWLINE: advance_line();
        CH_TAB: begin
          pad = TAB_STOP - (cur_col % TAB_STOP);
          repeat (pad) store_glyph(CH_SPACE);
        end
        CH_RETURN: begin
          for (c = 0; c < cur_col; c++) screen[cur_row * COLS + c] = {blank_attr, CH_SPACE};
          cur_col = 0;
        end
        default: store_glyph(ch);
      endcase
    end
    r.cursor_row = cur_row[ROW_W-1:0];
    r.cursor_col = cur_col[COL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    console_report_t want;
    if (rst) begin
      clear_screen();
      predicted_reports.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_TEXT_COLOR) fg_attr = pwdata[7:0];
          else blank_attr = pwdata[7:0];
        end else begin
          check_field("prdata", (paddr[2] == REG_TEXT_COLOR) ? {24'd0, fg_attr}
                                                             : {24'd0, blank_attr}, prdata);
        end
      end
      if (start && !busy)
        predicted_reports.push_back(predict_report(req_type, char_code, end_of_text,
                                                   read_row, read_col));
      if (done) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          err_cnt++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("cell_char", want.cell_char, cell_char);
          check_field("cell_color", want.cell_color, cell_color);
          check_field("cursor_row", want.cursor_row, cursor_row);
          check_field("cursor_col", want.cursor_col, cursor_col);
          check_field("write_done", want.write_done, write_done);
          check_cnt++;
        end
      end
    end
    outstanding <= predicted_reports.size();
    errors      <= err_cnt;
    checked     <= check_cnt;
    scrolls     <= scroll_cnt;
  end

endmodule

/* verif/text_console_cursor_scroll_unit_tb.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit_tb
// Drives put and read transactions into the text console unit in random
// bursts: a directed opening over field extremes, tab, carriage return,
// newline and out-of-range reads, then random text lines that wrap and scroll,
// under four color settings written over APB. The checker does the scoring.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_tb;
  import tccs_pkg::*;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             req_type;
  logic [7:0]       char_code;
  logic             end_of_text;
  logic [ROW_W-1:0] read_row;
  logic [COL_W-1:0] read_col;
  logic             done;
  logic [7:0]       cell_char;
  logic [7:0]       cell_color;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic             write_done;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int               errors;
  int               outstanding;
  int               checked;
  int               scrolls;

  int n_puts;
  int n_reads;
  int burst_left;

  text_console_cursor_scroll_unit dut (.*);
  tccs_console_checker checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_req(logic rq, logic [7:0] ch, logic eot,
                          logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    if (burst_left == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    @(negedge clk);
    start       = 1'b1;
    req_type    = rq;
    char_code   = ch;
    end_of_text = eot;
    read_row    = rr;
    read_col    = rc;
    do @(posedge clk); while (busy);
    burst_left--;
    if (rq == REQ_READ) n_reads++;
    else n_puts++;
  endtask

  task automatic put_char(logic [7:0] ch, logic eot);
    send_req(REQ_PUT, ch, eot, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_cell(logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    send_req(REQ_READ, 8'($urandom), 1'($urandom), rr, rc);
  endtask

  task automatic settle();
    @(negedge clk);
    start      = 1'b0;
    burst_left = 0;
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [7:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = {24'($urandom), val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_line();
    int         len;
    int         pick;
    int         k;
    logic [7:0] ch;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 30);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) ch = 8'($urandom_range(32, 126));
      else if (pick < 90) ch = CH_TAB;
      else ch = 8'($urandom_range(0, 255));
      put_char(ch, 1'b0);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) put_char(CH_NEWLINE, 1'b1);
    else if (pick < 9) put_char(CH_RETURN, 1'b1);
    else put_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_random(int count);
    int stop_at;
    int pick;
    stop_at = n_puts + n_reads + count;
    while (n_puts + n_reads < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_line();
      else if (pick < 90) begin
        if ($urandom_range(0, 4) == 0) read_cell(ROW_W'($urandom), COL_W'($urandom));
        else if ($urandom_range(0, 1) == 0)
          read_cell(ROW_W'(ROWS - 1 - $urandom_range(0, 3)), COL_W'($urandom_range(0, COLS - 1)));
        else
          read_cell(ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom_range(0, COLS - 1)));
      end else put_char(8'($urandom_range(0, 255)), 1'($urandom));
    end
  endtask

  initial begin
    logic [7:0] text_attr;
    logic [7:0] blank_attr;
    int         phase;
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = REQ_PUT;
    char_code   = 8'd0;
    end_of_text = 1'b0;
    read_row    = '0;
    read_col    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    n_puts      = 0;
    n_reads     = 0;
    burst_left  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    settle();

    read_cell(5'd31, 7'd127);
    read_cell(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
    read_cell(5'd0, 7'd0);
    read_cell(ROW_W'(ROWS), 7'd0);
    read_cell(5'd0, COL_W'(COLS));
    put_char(8'h41, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(8'h00, 1'b1);
    put_char(CH_TAB, 1'b0);
    put_char(CH_TAB, 1'b1);
    put_char(8'h7F, 1'b0);
    put_char(8'h80, 1'b0);
    put_char(CH_RETURN, 1'b1);
    put_char(CH_RETURN, 1'b0);
    put_char(8'h78, 1'b0);
    put_char(CH_NEWLINE, 1'b1);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd8);
    read_cell(5'd0, 7'd9);
    read_cell(5'd1, 7'd0);
    settle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin text_attr = 8'h00; blank_attr = 8'hFF; end
        1: begin text_attr = 8'hFF; blank_attr = 8'h00; end
        default: begin text_attr = 8'($urandom); blank_attr = 8'($urandom); end
      endcase
      apb_access(1'b1, REG_TEXT_COLOR, text_attr);
      apb_access(1'b1, REG_BLANK_COLOR, blank_attr);
      apb_access(1'b0, REG_TEXT_COLOR, 8'd0);
      apb_access(1'b0, REG_BLANK_COLOR, 8'd0);
      run_random(330);
      settle();
    end

    repeat (200) @(posedge clk);
    $display("Ran %0d put and %0d read transactions under 4 color settings;", n_puts, n_reads);
    $display("%0d results checked, %0d scrolls predicted.", checked, scrolls);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
